// File: hw/rtl/brm_pkg.sv
`timescale 1ns / 1ps
// Shared widths, register indexes, reset values and types for the rate meter.
package brm_pkg;

  localparam int BYTE_W     = 32;
  localparam int TIME_W     = 32;
  localparam int BUCKET_W   = 40;
  localparam int INST_W     = 43;
  localparam int WIN_W      = 49;
  localparam int TOTAL_W    = 48;
  localparam int SMOOTH_W   = 59;
  localparam int FRAC_W     = 16;
  localparam int WEIGHT_W   = 17;
  localparam int WSEC_W     = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;
  localparam int BIT_SHIFT  = 3;                  // bytes to bits
  localparam int WIN_SAT_W  = WIN_W - BIT_SHIFT;  // byte sum above this saturates

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT = 2'd1;

  localparam logic [WSEC_W-1:0]   WINDOW_RESET = 7'd10;
  localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 17'd6554;
  localparam logic [WEIGHT_W-1:0] Q_ONE        = 17'h10000;

  typedef logic [BUCKET_W-1:0] bucket_t;

  typedef struct packed {
    logic                accepted;
    logic [INST_W-1:0]   inst_rate;
    logic [WIN_W-1:0]    window_rate;
    logic [INST_W-1:0]   smoothed_rate;
    logic [WIN_W-1:0]    peak_rate;
    logic [TOTAL_W-1:0]  byte_total;
  } result_t;

endpackage

// File: hw/rtl/brm_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces: input items, results and register writes.
interface brm_item_if;
  logic                              valid;
  logic                              ready;
  logic signed [brm_pkg::BYTE_W-1:0] byte_count;
  logic        [brm_pkg::TIME_W-1:0] now_seconds;

  modport source (output valid, output byte_count, output now_seconds, input ready);
  modport sink   (input valid, input byte_count, input now_seconds, output ready);
endinterface

interface brm_result_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [brm_pkg::INST_W-1:0]    inst_rate;
  logic [brm_pkg::WIN_W-1:0]     window_rate;
  logic [brm_pkg::INST_W-1:0]    smoothed_rate;
  logic [brm_pkg::WIN_W-1:0]     peak_rate;
  logic [brm_pkg::TOTAL_W-1:0]   byte_total;

  modport source (output valid, output accepted, output inst_rate, output window_rate,
                  output smoothed_rate, output peak_rate, output byte_total, input ready);
  modport sink   (input valid, input accepted, input inst_rate, input window_rate,
                  input smoothed_rate, input peak_rate, input byte_total, output ready);
endinterface

interface brm_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [brm_pkg::CFG_IDX_W-1:0]     index;
  logic [brm_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/brm_bucket_mem.sv
`timescale 1ns / 1ps
// Per-second byte bucket ring: one write port, one registered read port.
module brm_bucket_mem #(
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_W-1:0]    waddr,
  input  brm_pkg::bucket_t     wdata,
  input  logic                 re,
  input  logic [ADDR_W-1:0]    raddr,
  output brm_pkg::bucket_t     rdata
);

  brm_pkg::bucket_t mem [DEPTH];

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/brm_ewma.sv
`timescale 1ns / 1ps
// EWMA update unit: holds the Q43.16 smoothed value, one shared 17x22 multiplier.
module brm_ewma (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [brm_pkg::WEIGHT_W-1:0]     weight,
  input  logic [brm_pkg::INST_W-1:0]       inst,
  output logic                             done,
  output logic [brm_pkg::SMOOTH_W-1:0]     smooth
);

  localparam int MUL_A_W = brm_pkg::WEIGHT_W;
  localparam int SPLIT   = 22;
  localparam int PROD_W  = MUL_A_W + SPLIT;
  localparam int ACC_W   = brm_pkg::SMOOTH_W + 2;

  localparam logic [2:0] PH_W_LO    = 3'd0;  // w * inst low part
  localparam logic [2:0] PH_W_HI    = 3'd1;  // w * inst high part
  localparam logic [2:0] PH_C_LO    = 3'd2;  // (1-w) * integer part, low
  localparam logic [2:0] PH_C_HI    = 3'd3;  // (1-w) * integer part, high
  localparam logic [2:0] PH_C_FRAC  = 3'd4;  // (1-w) * fraction, truncated

  logic                          busy;
  logic [2:0]                    phase;
  logic [MUL_A_W-1:0]            wt;
  logic [MUL_A_W-1:0]            wc;
  logic [MUL_A_W-1:0]            w_sat;
  logic [MUL_A_W-1:0]            mul_a;
  logic [SPLIT-1:0]              mul_b;
  logic [PROD_W-1:0]             prod;
  logic [2:0]                    prod_ph;
  logic                          prod_v;
  logic [ACC_W-1:0]              acc;
  logic [ACC_W-1:0]              term;
  logic [ACC_W-1:0]              acc_sum;

  assign w_sat = (weight > brm_pkg::Q_ONE) ? brm_pkg::Q_ONE : weight;

  always_comb begin
    case (phase)
      PH_W_LO: begin
        mul_a = wt;
        mul_b = inst[SPLIT-1:0];
      end
      PH_W_HI: begin
        mul_a = wt;
        mul_b = SPLIT'(inst[brm_pkg::INST_W-1:SPLIT]);
      end
      PH_C_LO: begin
        mul_a = wc;
        mul_b = smooth[brm_pkg::FRAC_W+SPLIT-1:brm_pkg::FRAC_W];
      end
      PH_C_HI: begin
        mul_a = wc;
        mul_b = SPLIT'(smooth[brm_pkg::SMOOTH_W-1:brm_pkg::FRAC_W+SPLIT]);
      end
      PH_C_FRAC: begin
        mul_a = wc;
        mul_b = SPLIT'(smooth[brm_pkg::FRAC_W-1:0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (prod_ph)
      PH_W_LO, PH_C_LO: term = ACC_W'(prod);
      PH_W_HI, PH_C_HI: term = ACC_W'(prod) << SPLIT;
      PH_C_FRAC:        term = ACC_W'(prod >> brm_pkg::FRAC_W);
      default:          term = '0;
    endcase
  end

  assign acc_sum = acc + term;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      phase   <= PH_W_LO;
      prod_v  <= 1'b0;
      prod_ph <= PH_W_LO;
      done    <= 1'b0;
      smooth  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        phase  <= PH_W_LO;
        acc    <= '0;
        wt     <= w_sat;
        wc     <= brm_pkg::Q_ONE - w_sat;
        prod_v <= 1'b0;
      end else if (busy) begin
        prod    <= mul_a * mul_b;
        prod_ph <= phase;
        prod_v  <= 1'b1;
        if (phase == PH_C_FRAC) begin
          busy <= 1'b0;
        end else begin
          phase <= phase + 3'd1;
        end
      end else begin
        prod_v <= 1'b0;
      end
      if (prod_v) begin
        if (prod_ph == PH_C_FRAC) begin
          smooth <= (|acc_sum[ACC_W-1:brm_pkg::SMOOTH_W]) ? '1
                                                           : acc_sum[brm_pkg::SMOOTH_W-1:0];
          done   <= 1'b1;
        end else begin
          acc <= acc_sum;
        end
      end
    end
  end

endmodule

// File: hw/rtl/bucketed_rate_meter_core.sv
`timescale 1ns / 1ps
// Rate meter top level: sequencer, running window sum and output register.
//
//  channel  role   transfer when          carries
//  -------  -----  ---------------------  ------------------------------------------
//  item     sink   valid & ready          byte_count, now_seconds
//  result   source valid & ready          accepted, rates, peak, byte_total
//  cfg      sink   valid & ready (ready=1) index (0 window_seconds, 1 ewma_weight), data
//
// A negative count goes straight to the output register. An accepted count first
// advances the ring by one bucket per elapsed second (capped at NUM_BUCKETS); the ring
// advance clears one bucket per cycle over the single memory write port. It then reads
// and writes the bucket, updates the window and peak, and runs the EWMA on one shared
// multiplier. After a window_seconds write the window sum is rebuilt with item.ready
// low. Reset is synchronous; the ring is then cleared with item.ready low. A result held
// by a stalled sink stalls the next result, and item.ready stays low while it waits.
module bucketed_rate_meter_core #(
  parameter int NUM_BUCKETS = 64
) (
  input  logic               clk,
  input  logic               rst,
  brm_item_if.sink           item,
  brm_result_if.source       result,
  brm_cfg_if.sink            cfg
);

  localparam int SLOT_W = $clog2(NUM_BUCKETS);
  localparam int CNT_W  = $clog2(NUM_BUCKETS + 1);
  localparam int SUM_W  = brm_pkg::BUCKET_W + CNT_W;
  localparam int SUMX_W = (SUM_W > brm_pkg::WIN_SAT_W) ? SUM_W : brm_pkg::WIN_SAT_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_BUCKETS - 1);
  localparam logic [CNT_W-1:0]  N_CNT     = CNT_W'(NUM_BUCKETS);
  localparam logic [CNT_W:0]    N_WIDE    = (CNT_W + 1)'(NUM_BUCKETS);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_RECALC = 4'd2;
  localparam logic [3:0] S_STEP   = 4'd3;
  localparam logic [3:0] S_READ   = 4'd4;
  localparam logic [3:0] S_WRITE  = 4'd5;
  localparam logic [3:0] S_WIN    = 4'd6;
  localparam logic [3:0] S_EWMA   = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;

  logic [3:0]                         state;
  logic [SLOT_W-1:0]                  cur_slot;
  logic [SLOT_W-1:0]                  walk;
  logic [SLOT_W-1:0]                  clr_ptr;
  logic [CNT_W-1:0]                   cnt;
  logic [CNT_W-1:0]                   steps_left;
  logic [brm_pkg::TIME_W-1:0]         bucket_second;
  logic [brm_pkg::BYTE_W-2:0]         raw;
  logic                               acc_flag;
  logic [brm_pkg::TOTAL_W-1:0]        total;
  logic [brm_pkg::INST_W-1:0]         last_inst;
  logic [brm_pkg::WIN_W-1:0]          last_window;
  logic [brm_pkg::WIN_W-1:0]          peak;
  logic [SUM_W-1:0]                   win_sum;
  logic                               dirty;
  logic [brm_pkg::WSEC_W-1:0]         window_seconds;
  logic [brm_pkg::WEIGHT_W-1:0]       ewma_weight;
  logic [1:0]                         acc_op;
  logic [1:0]                         acc_op_next;
  brm_pkg::result_t                   res;
  logic                               res_valid;

  logic                               mem_we;
  logic [SLOT_W-1:0]                  mem_waddr;
  brm_pkg::bucket_t                   mem_wdata;
  logic                               mem_re;
  logic [SLOT_W-1:0]                  mem_raddr;
  brm_pkg::bucket_t                   mem_rdata;

  logic                               ewma_start;
  logic                               ewma_done;
  logic [brm_pkg::SMOOTH_W-1:0]       smooth;

  logic                               item_xfer;
  logic                               cfg_xfer;
  logic [CNT_W-1:0]                   weff;
  logic [SLOT_W-1:0]                  slot_inc;
  logic [SLOT_W-1:0]                  walk_dec;
  logic [CNT_W:0]                     drop_sum;
  logic [SLOT_W-1:0]                  drop_slot;
  logic [brm_pkg::TIME_W-1:0]         delta;
  logic [CNT_W-1:0]                   steps;
  logic [brm_pkg::TOTAL_W:0]          total_sum;
  logic [brm_pkg::BUCKET_W:0]         bucket_sum;
  brm_pkg::bucket_t                   new_b;
  logic [SUMX_W-1:0]                  sum_x;
  logic [brm_pkg::WIN_W-1:0]          win_val;

  assign item_xfer  = item.valid && item.ready;
  assign cfg_xfer   = cfg.valid && cfg.ready;
  assign item.ready = (state == S_IDLE) && !dirty;
  assign cfg.ready  = 1'b1;

  always_comb begin
    if (32'(window_seconds) > 32'(NUM_BUCKETS)) begin
      weff = N_CNT;
    end else begin
      weff = CNT_W'(window_seconds);
    end
  end

  assign slot_inc = (cur_slot == LAST_SLOT) ? '0 : cur_slot + SLOT_W'(1);
  assign walk_dec = (walk == '0) ? LAST_SLOT : walk - SLOT_W'(1);

  // bucket that leaves the window when the ring moves to slot_inc
  assign drop_sum  = (CNT_W + 1)'(slot_inc) + N_WIDE - (CNT_W + 1)'(weff);
  assign drop_slot = (drop_sum >= N_WIDE) ? SLOT_W'(drop_sum - N_WIDE) : SLOT_W'(drop_sum);

  assign delta = item.now_seconds - bucket_second;
  assign steps = (delta > 32'(NUM_BUCKETS)) ? N_CNT : CNT_W'(delta);

  assign total_sum  = {1'b0, total} + (brm_pkg::TOTAL_W + 1)'(item.byte_count[brm_pkg::BYTE_W-2:0]);
  assign bucket_sum = {1'b0, mem_rdata} + (brm_pkg::BUCKET_W + 1)'(raw);
  assign new_b      = bucket_sum[brm_pkg::BUCKET_W] ? '1 : bucket_sum[brm_pkg::BUCKET_W-1:0];

  assign sum_x   = SUMX_W'(win_sum);
  assign win_val = (|(sum_x >> brm_pkg::WIN_SAT_W)) ? '1
                 : {sum_x[brm_pkg::WIN_SAT_W-1:0], {brm_pkg::BIT_SHIFT{1'b0}}};

  assign ewma_start = (state == S_WIN);

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = cur_slot;
    mem_wdata   = '0;
    mem_re      = 1'b0;
    mem_raddr   = cur_slot;
    acc_op_next = OP_NONE;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr;
      end
      S_RECALC: begin
        if (!dirty && cnt != weff) begin
          mem_re      = 1'b1;
          mem_raddr   = walk;
          acc_op_next = OP_ADD;
        end
      end
      S_STEP: begin
        mem_we    = 1'b1;
        mem_waddr = slot_inc;
        if (weff != '0) begin
          mem_re      = 1'b1;
          mem_raddr   = drop_slot;
          acc_op_next = OP_SUB;
        end
      end
      S_READ: begin
        mem_re = 1'b1;
      end
      S_WRITE: begin
        mem_we    = 1'b1;
        mem_wdata = new_b;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLEAR;
      clr_ptr        <= '0;
      cur_slot       <= '0;
      walk           <= '0;
      cnt            <= '0;
      steps_left     <= '0;
      bucket_second  <= '0;
      acc_flag       <= 1'b0;
      total          <= '0;
      last_inst      <= '0;
      last_window    <= '0;
      peak           <= '0;
      win_sum        <= '0;
      dirty          <= 1'b0;
      window_seconds <= brm_pkg::WINDOW_RESET;
      ewma_weight    <= brm_pkg::WEIGHT_RESET;
      acc_op         <= OP_NONE;
      res_valid      <= 1'b0;
    end else begin
      acc_op <= acc_op_next;
      if (res_valid && result.ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (clr_ptr == LAST_SLOT) begin
            state <= S_IDLE;
          end else begin
            clr_ptr <= clr_ptr + SLOT_W'(1);
          end
        end
        S_IDLE: begin
          if (dirty) begin
            state   <= S_RECALC;
            win_sum <= '0;
            walk    <= cur_slot;
            cnt     <= '0;
            dirty   <= 1'b0;
          end else if (item_xfer) begin
            if (item.byte_count[brm_pkg::BYTE_W-1]) begin
              acc_flag <= 1'b0;
              state    <= S_OUT;
            end else begin
              acc_flag      <= 1'b1;
              raw           <= item.byte_count[brm_pkg::BYTE_W-2:0];
              total         <= total_sum[brm_pkg::TOTAL_W] ? '1
                                                            : total_sum[brm_pkg::TOTAL_W-1:0];
              bucket_second <= item.now_seconds;
              steps_left    <= steps;
              state         <= (delta == '0) ? S_READ : S_STEP;
            end
          end
        end
        S_RECALC: begin
          // walk the newest buckets back from the current slot
          if (dirty) begin
            state <= S_IDLE;
          end else begin
            if (acc_op == OP_ADD) begin
              win_sum <= win_sum + SUM_W'(mem_rdata);
            end
            if (cnt != weff) begin
              walk <= walk_dec;
              cnt  <= cnt + CNT_W'(1);
            end else if (acc_op == OP_NONE) begin
              state <= S_IDLE;
            end
          end
        end
        S_STEP: begin
          if (acc_op == OP_SUB) begin
            win_sum <= win_sum - SUM_W'(mem_rdata);
          end
          cur_slot   <= slot_inc;
          steps_left <= steps_left - CNT_W'(1);
          if (steps_left == CNT_W'(1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (acc_op == OP_SUB) begin
            win_sum <= win_sum - SUM_W'(mem_rdata);
          end
          state <= S_WRITE;
        end
        S_WRITE: begin
          last_inst <= {new_b, {brm_pkg::BIT_SHIFT{1'b0}}};
          if (weff != '0) begin
            win_sum <= win_sum + SUM_W'(new_b - mem_rdata);
          end
          state <= S_WIN;
        end
        S_WIN: begin
          last_window <= win_val;
          if (win_val > peak) begin
            peak <= win_val;
          end
          state <= S_EWMA;
        end
        S_EWMA: begin
          if (ewma_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!res_valid || result.ready) begin
            res.accepted      <= acc_flag;
            res.inst_rate     <= last_inst;
            res.window_rate   <= last_window;
            res.smoothed_rate <= smooth[brm_pkg::SMOOTH_W-1:brm_pkg::FRAC_W];
            res.peak_rate     <= peak;
            res.byte_total    <= total;
            res_valid         <= 1'b1;
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cfg_xfer) begin
        case (cfg.index)
          brm_pkg::CFG_WINDOW: begin
            window_seconds <= cfg.data[brm_pkg::WSEC_W-1:0];
            dirty          <= 1'b1;
          end
          brm_pkg::CFG_WEIGHT: begin
            ewma_weight <= cfg.data;
          end
          default: begin
          end
        endcase
      end
    end
  end

  assign result.valid         = res_valid;
  assign result.accepted      = res.accepted;
  assign result.inst_rate     = res.inst_rate;
  assign result.window_rate   = res.window_rate;
  assign result.smoothed_rate = res.smoothed_rate;
  assign result.peak_rate     = res.peak_rate;
  assign result.byte_total    = res.byte_total;

  brm_bucket_mem #(
    .DEPTH  (NUM_BUCKETS),
    .ADDR_W (SLOT_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  brm_ewma u_ewma (
    .clk    (clk),
    .rst    (rst),
    .start  (ewma_start),
    .weight (ewma_weight),
    .inst   (last_inst),
    .done   (ewma_done),
    .smooth (smooth)
  );

endmodule

// File: hw/rtl/brm_checker.sv
`timescale 1ns / 1ps
// Port-level checks on the result channel of the rate meter, bound to the top level.
module brm_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic                            out_accepted,
  input logic [brm_pkg::INST_W-1:0]      out_inst_rate,
  input logic [brm_pkg::WIN_W-1:0]       out_window_rate,
  input logic [brm_pkg::WIN_W-1:0]       out_peak_rate,
  input logic [brm_pkg::TOTAL_W-1:0]     out_byte_total
);

  logic [brm_pkg::INST_W-1:0]  prev_inst;
  logic [brm_pkg::WIN_W-1:0]   prev_window;
  logic [brm_pkg::WIN_W-1:0]   prev_peak;
  logic [brm_pkg::TOTAL_W-1:0] prev_total;

  // values of the last result transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_inst   <= '0;
      prev_window <= '0;
      prev_peak   <= '0;
      prev_total  <= '0;
    end else if (out_valid && out_ready) begin
      prev_inst   <= out_inst_rate;
      prev_window <= out_window_rate;
      prev_peak   <= out_peak_rate;
      prev_total  <= out_byte_total;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte_total) && $stable(out_peak_rate))
    else $error("result changed while stalled");

  a_inst_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_accepted |-> out_inst_rate[brm_pkg::BIT_SHIFT-1:0] == '0)
    else $error("inst_rate not a whole number of bytes");

  a_peak_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_peak_rate >= out_window_rate && out_peak_rate >= prev_peak
                  && out_byte_total >= prev_total)
    else $error("peak or total went backwards");

  a_ignored_repeats: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_accepted |-> out_inst_rate == prev_inst && out_window_rate == prev_window
                                   && out_peak_rate == prev_peak && out_byte_total == prev_total)
    else $error("ignored count changed the reported state");

endmodule

bind bucketed_rate_meter_core brm_checker u_brm_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .out_accepted    (result.accepted),
  .out_inst_rate   (result.inst_rate),
  .out_window_rate (result.window_rate),
  .out_peak_rate   (result.peak_rate),
  .out_byte_total  (result.byte_total)
);

// File: bench/rate_meter_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the rate meter: mirrors the meter state and checks every reading.
module rate_meter_checker #(
  parameter int RING = 64
) (
  input  logic  clk,
  input  logic  rst,
  brm_item_if   item_ch,
  brm_result_if res_ch,
  brm_cfg_if    cfg_ch,
  output int    fail_count,
  output int    outstanding
);

  localparam logic [63:0] TOTAL_MAX  = (64'd1 << brm_pkg::TOTAL_W) - 64'd1;
  localparam logic [63:0] BUCKET_MAX = (64'd1 << brm_pkg::BUCKET_W) - 64'd1;
  localparam logic [63:0] WIN_MAX    = (64'd1 << brm_pkg::WIN_W) - 64'd1;
  localparam logic [63:0] SMOOTH_MAX = (64'd1 << brm_pkg::SMOOTH_W) - 64'd1;
  localparam logic [63:0] FRAC_MASK  = (64'd1 << brm_pkg::FRAC_W) - 64'd1;

  // mirrored meter state
  logic [brm_pkg::BUCKET_W-1:0] sec_bytes [RING];
  int                           head;
  logic [brm_pkg::TIME_W-1:0]   head_second;
  logic [brm_pkg::TOTAL_W-1:0]  mirror_total;
  logic [brm_pkg::SMOOTH_W-1:0] ewma_acc;
  logic [brm_pkg::WIN_W-1:0]    peak_bits;
  logic [brm_pkg::INST_W-1:0]   inst_bits;
  logic [brm_pkg::WIN_W-1:0]    window_bits;
  logic [brm_pkg::WSEC_W-1:0]   window_len;
  logic [brm_pkg::WEIGHT_W-1:0] weight;

  brm_pkg::result_t readings_due[$];
  int               errors = 0;

  // Applies one event to the mirrored state and returns the reading it yields.
  task automatic reading_for(input logic [brm_pkg::BYTE_W-1:0] count,
                             input logic [brm_pkg::TIME_W-1:0] stamp,
                             output brm_pkg::result_t r);
    logic [63:0]                sum, w, hi, lo, part, s, shifted;
    logic [brm_pkg::TIME_W-1:0] elapsed;
    int                         steps, n, idx;
    // negative counts leave everything alone, time included
    if (!count[brm_pkg::BYTE_W-1]) begin
      sum = 64'(mirror_total) + 64'(count);
      mirror_total = (sum > TOTAL_MAX) ? TOTAL_MAX[brm_pkg::TOTAL_W-1:0]
                                       : sum[brm_pkg::TOTAL_W-1:0];

      elapsed = stamp - head_second;
      if (elapsed != 0) begin
        steps = (elapsed > RING) ? RING : int'(elapsed);
        for (int k = 0; k < steps; k++) begin
          head = (head + 1) % RING;
          sec_bytes[head] = '0;
        end
        head_second = stamp;
      end

      sum = 64'(sec_bytes[head]) + 64'(count);
      sec_bytes[head] = (sum > BUCKET_MAX) ? BUCKET_MAX[brm_pkg::BUCKET_W-1:0]
                                           : sum[brm_pkg::BUCKET_W-1:0];
      shifted = 64'(sec_bytes[head]) << brm_pkg::BIT_SHIFT;
      inst_bits = shifted[brm_pkg::INST_W-1:0];

      n = (window_len > RING) ? RING : int'(window_len);
      sum = '0;
      idx = head;
      for (int k = 0; k < n; k++) begin
        sum += 64'(sec_bytes[idx]);
        idx = (idx == 0) ? RING - 1 : idx - 1;
      end
      shifted = sum << brm_pkg::BIT_SHIFT;
      window_bits = (sum > (WIN_MAX >> brm_pkg::BIT_SHIFT)) ? WIN_MAX[brm_pkg::WIN_W-1:0]
                                                           : shifted[brm_pkg::WIN_W-1:0];

      // Q1.16 weight, clamped to 1.0; old value's fraction truncated separately
      w = (weight > brm_pkg::Q_ONE) ? 64'(brm_pkg::Q_ONE) : 64'(weight);
      hi = 64'(ewma_acc) >> brm_pkg::FRAC_W;
      lo = 64'(ewma_acc) & FRAC_MASK;
      part = (64'(brm_pkg::Q_ONE) - w) * hi
           + (((64'(brm_pkg::Q_ONE) - w) * lo) >> brm_pkg::FRAC_W);
      s = w * 64'(inst_bits) + part;
      ewma_acc = (s > SMOOTH_MAX) ? SMOOTH_MAX[brm_pkg::SMOOTH_W-1:0]
                                  : s[brm_pkg::SMOOTH_W-1:0];

      if (window_bits > peak_bits) peak_bits = window_bits;
    end
    r.accepted      = !count[brm_pkg::BYTE_W-1];
    r.inst_rate     = inst_bits;
    r.window_rate   = window_bits;
    r.smoothed_rate = ewma_acc[brm_pkg::SMOOTH_W-1:brm_pkg::FRAC_W];
    r.peak_rate     = peak_bits;
    r.byte_total    = mirror_total;
  endtask

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : watch
    brm_pkg::result_t want, got;
    if (rst) begin
      for (int k = 0; k < RING; k++) sec_bytes[k] = '0;
      head         = 0;
      head_second  = '0;
      mirror_total = '0;
      ewma_acc     = '0;
      peak_bits    = '0;
      inst_bits    = '0;
      window_bits  = '0;
      window_len   = brm_pkg::WINDOW_RESET;
      weight       = brm_pkg::WEIGHT_RESET;
      readings_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          brm_pkg::CFG_WINDOW: window_len = cfg_ch.data[brm_pkg::WSEC_W-1:0];
          brm_pkg::CFG_WEIGHT: weight = cfg_ch.data[brm_pkg::WEIGHT_W-1:0];
          default: ;
        endcase
      end

      // readings leave before a new event enters, so check first
      if (res_ch.valid && res_ch.ready) begin
        got.accepted      = res_ch.accepted;
        got.inst_rate     = res_ch.inst_rate;
        got.window_rate   = res_ch.window_rate;
        got.smoothed_rate = res_ch.smoothed_rate;
        got.peak_rate     = res_ch.peak_rate;
        got.byte_total    = res_ch.byte_total;
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected reading: expected none, actual accepted=%0d total=%0d",
                   $time, got.accepted, got.byte_total);
          errors++;
        end else begin
          want = readings_due.pop_front();
          check_field("accepted", 64'(want.accepted), 64'(got.accepted));
          check_field("inst_rate", 64'(want.inst_rate), 64'(got.inst_rate));
          check_field("window_rate", 64'(want.window_rate), 64'(got.window_rate));
          check_field("smoothed_rate", 64'(want.smoothed_rate), 64'(got.smoothed_rate));
          check_field("peak_rate", 64'(want.peak_rate), 64'(got.peak_rate));
          check_field("byte_total", 64'(want.byte_total), 64'(got.byte_total));
        end
      end

      if (item_ch.valid && item_ch.ready) begin
        reading_for(item_ch.byte_count, item_ch.now_seconds, want);
        readings_due.push_back(want);
      end
    end
    fail_count  <= errors;
    outstanding <= readings_due.size();
  end

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
// Testbench top for the rate meter: clock, reset, traffic, register writes and verdict.
module tb;

  localparam int RING_DEPTH  = 64;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 200;
  localparam int SAT_PHASE   = 7;
  localparam int SAT_ITEMS   = 530;   // enough max-size transfers to pin one bucket

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_SPARSE, SINK_PERIODIC} sink_mode_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   outstanding;
  int   burst_left = 0;
  bit   long_hold = 1'b0;
  bit   hold_done = 1'b0;
  logic [brm_pkg::TIME_W-1:0] cur_time;

  brm_item_if   item_ch ();
  brm_result_if res_ch ();
  brm_cfg_if    cfg_ch ();

  bucketed_rate_meter_core #(.NUM_BUCKETS(RING_DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  rate_meter_checker #(.RING(RING_DEPTH)) chk (
    .clk         (clk),
    .rst         (rst),
    .item_ch     (item_ch),
    .res_ch      (res_ch),
    .cfg_ch      (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Called on a falling edge; returns on the falling edge after the transfer.
  task automatic send_item(input logic signed [brm_pkg::BYTE_W-1:0] count,
                           input logic [brm_pkg::TIME_W-1:0] stamp);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if ($urandom_range(0, 19) == 0) gap = 60;
      if (gap != 0) begin
        item_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    item_ch.valid       <= 1'b1;
    item_ch.byte_count  <= count;
    item_ch.now_seconds <= stamp;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic cfg_put(input logic [brm_pkg::CFG_IDX_W-1:0] idx,
                         input logic [brm_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_config(input logic [brm_pkg::CFG_DATA_W-1:0] win,
                              input logic [brm_pkg::CFG_DATA_W-1:0] wgt);
    cfg_put(brm_pkg::CFG_WINDOW, win);
    cfg_put(brm_pkg::CFG_WEIGHT, wgt);
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random stall patterns, plus one long hold-off on request
  initial begin : sink_pacing
    sink_mode_t mode;
    int span;
    int tick;
    res_ch.ready = 1'b0;
    tick = 0;
    forever begin
      mode = sink_mode_t'($urandom_range(0, 3));
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(negedge clk);
        tick++;
        if (long_hold && !hold_done) begin
          // meter backs up and stops taking items
          res_ch.ready <= 1'b0;
          repeat (HOLD_CYCLES) @(negedge clk);
          hold_done = 1'b1;
        end
        case (mode)
          SINK_OPEN:   res_ch.ready <= 1'b1;
          SINK_COIN:   res_ch.ready <= 1'($urandom_range(0, 1));
          SINK_SPARSE: res_ch.ready <= ($urandom_range(0, 7) == 0);
          default:     res_ch.ready <= ((tick % 5) < 2);
        endcase
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : stimulus
    int ph;
    int roll;
    logic [brm_pkg::CFG_DATA_W-1:0]    win_d;
    logic [brm_pkg::CFG_DATA_W-1:0]    wgt_d;
    logic signed [brm_pkg::BYTE_W-1:0] bc;
    logic [brm_pkg::TIME_W-1:0]        ts;

    rst                 = 1'b1;
    item_ch.valid       = 1'b0;
    item_ch.byte_count  = '0;
    item_ch.now_seconds = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = brm_pkg::CFG_WINDOW;
    cfg_ch.data         = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    // ring clear after reset holds item.ready low
    @(negedge clk);
    while (!item_ch.ready) @(negedge clk);

    // directed, reset register values
    send_item(32'sd100, 32'd0);
    send_item(32'sd0, 32'd0);
    send_item(32'shFFFF_FFFF, 32'd0);          // minus one: ignored
    send_item(32'sh8000_0000, 32'hFFFF_FFFF);  // most negative, far time: ignored
    send_item(32'sh7FFF_FFFF, 32'd1);
    send_item(32'sd1, 32'd1);
    send_item(32'sd50, 32'd4);
    send_item(32'sd7, 32'd70);                 // more than a ring elapsed
    send_item(32'sd9, 32'd69);                 // time runs backwards
    send_item(32'sd3, 32'hFFFF_FFFF);
    send_item(32'sd4, 32'd0);                  // wraps forward by one
    send_item(32'sd12345, 32'd64);             // exactly a ring
    send_item(32'sd1, 32'd127);
    send_item(32'sh7FFF_FFFF, 32'd127);
    cur_time = 32'd127;
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin win_d = 17'd1;      wgt_d = 17'h10000; end
        1:       begin win_d = 17'd64;     wgt_d = 17'd0;     end
        2:       begin win_d = 17'd0;      wgt_d = 17'd32768; end
        3:       begin win_d = 17'd127;    wgt_d = 17'h1FFFF; end
        4:       begin win_d = 17'd65;     wgt_d = 17'd1;     end
        5:       begin
          win_d = 17'($urandom_range(1, 64));
          wgt_d = 17'($urandom_range(0, 65536));
        end
        6:       begin win_d = 17'h1FF8A;  wgt_d = 17'd6554;  end  // upper data bits dropped
        default: begin win_d = 17'd64;     wgt_d = 17'd65535; end
      endcase
      write_config(win_d, wgt_d);
      if (ph == 2) long_hold = 1'b1;

      if (ph == SAT_PHASE) begin
        cur_time = cur_time + 32'd1;
        repeat (SAT_ITEMS) send_item(32'sh7FFF_FFFF, cur_time);
      end else begin
        repeat (PHASE_ITEMS) begin
          roll = $urandom_range(0, 99);
          if (roll < 8) begin
            bc = $urandom | 32'h8000_0000;
            ts = $urandom;
          end else begin
            // mostly steady clock, with jumps, rollbacks and random leaps
            roll = $urandom_range(0, 99);
            if (roll >= 97) cur_time = $urandom;
            else if (roll >= 94) cur_time = cur_time - $urandom_range(1, 1000);
            else if (roll >= 90) cur_time = cur_time + $urandom_range(60, 70);
            else if (roll >= 80) cur_time = cur_time + $urandom_range(2, 10);
            else if (roll >= 50) cur_time = cur_time + 32'd1;
            ts = cur_time;
            roll = $urandom_range(0, 99);
            if (roll < 40) bc = $urandom_range(0, 2000);
            else if (roll < 70) bc = $urandom_range(0, 1 << 20);
            else if (roll < 90) bc = $urandom & 32'h7FFF_FFFF;
            else if (roll < 95) bc = 32'sd0;
            else bc = 32'sh7FFF_FFFF;
          end
          send_item(bc, ts);
        end
      end
      settle();
    end

    repeat (100) @(negedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/brm_pkg.sv
hw/rtl/brm_if.sv
hw/rtl/brm_bucket_mem.sv
hw/rtl/brm_ewma.sv
hw/rtl/bucketed_rate_meter_core.sv
hw/rtl/brm_checker.sv
bench/rate_meter_checker.sv
bench/tb.sv
